// ===== hdl/tlvcrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLV connect request parser package
// Beat types, result kinds and configuration register indexes shared by the
// parser core, the result queue and the top level.
// ----------------------------------------------------------------------------
package tlvcrp_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int TAG_W     = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_NAME_TAG     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PASS_TAG     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PASS_ALT_TAG = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEC_TAG      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEC_ALT_TAG  = 3'd4;

  localparam logic [TAG_W-1:0] NAME_TAG_RST     = 8'd1;
  localparam logic [TAG_W-1:0] PASS_TAG_RST     = 8'd2;
  localparam logic [TAG_W-1:0] PASS_ALT_TAG_RST = 8'd3;
  localparam logic [TAG_W-1:0] SEC_TAG_RST      = 8'd4;
  localparam logic [TAG_W-1:0] SEC_ALT_TAG_RST  = 8'd5;

  localparam logic [1:0] KIND_NAME    = 2'd0;
  localparam logic [1:0] KIND_PASS    = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [10:0] pkt_len;
    logic        packet_end;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] offset;
    logic [7:0] value_byte;
    logic [5:0] name_len;
    logic [5:0] pass_len;
    logic [7:0] security_code;
    logic       config_valid;
    logic       summary_last;
  } out_beat_t;

  typedef struct packed {
    logic [1:0] beats;
    out_beat_t  first;
    out_beat_t  second;
  } push_t;

endpackage

// ===== hdl/tlvcrp_out_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLV connect request parser result queue
// Four-entry queue that takes up to two result beats per cycle and hands
// out one beat per cycle on the output channel while out_ready is high.
// ----------------------------------------------------------------------------
module tlvcrp_out_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  tlvcrp_pkg::push_t     push,
  output logic                  space_ok,
  output logic                  out_valid,
  input  logic                  out_ready,
  output tlvcrp_pkg::out_beat_t out_data
);
  import tlvcrp_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  out_beat_t          mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign space_ok  = (count <= CNT_W'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.beats != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.beats == 2'd2) begin
      mem[PTR_W'(wr_ptr + 1'b1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= PTR_W'(wr_ptr + PTR_W'(push.beats));
      if (pop) begin
        rd_ptr <= PTR_W'(rd_ptr + 1'b1);
      end
      count <= CNT_W'(count + CNT_W'(push.beats) - CNT_W'(pop));
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push.beats != 2'd0) |-> (CNT_W'(count + CNT_W'(push.beats)) <= CNT_W'(DEPTH)))
    else $error("result queue written while full");

  a_count_track: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> count == CNT_W'($past(count) + CNT_W'($past(push.beats)) - CNT_W'($past(pop))))
    else $error("result queue count lost track of pushes and pops");
`endif

endmodule

// ===== hdl/tlvcrp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLV connect request parser core
// Input register, tag registers and the record walk. Each registered beat
// updates the parse state and pushes its results once the queue has space.
// ----------------------------------------------------------------------------
module tlvcrp_core #(
  parameter int PAYLOAD_LEN_MAX = 2047,
  parameter int NAME_MAX        = 32,
  parameter int PASS_MAX        = 63
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  tlvcrp_pkg::in_beat_t                in_data,
  input  logic                                cfg_wr_en,
  input  logic [tlvcrp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tlvcrp_pkg::TAG_W-1:0]        cfg_wdata,
  input  logic                                space_ok,
  output tlvcrp_pkg::push_t                   push
);
  import tlvcrp_pkg::*;

  localparam int POS_W = $clog2(PAYLOAD_LEN_MAX + 1);
  localparam int LEN_W = (POS_W > 11) ? POS_W : 11;
  localparam int SUM_W = LEN_W + 2;
  localparam int NL_W  = $clog2(NAME_MAX + 1);
  localparam int PL_W  = $clog2(PASS_MAX + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(PAYLOAD_LEN_MAX);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(PAYLOAD_LEN_MAX);

  typedef enum logic [1:0] {PH_TAG, PH_LEN, PH_VAL, PH_STOP} phase_t;
  typedef enum logic [1:0] {TGT_NONE, TGT_NAME, TGT_PASS, TGT_SEC} target_t;

  logic [TAG_W-1:0] name_tag, pass_tag, pass_alt_tag, sec_tag, sec_alt_tag;

  logic        s1_valid;
  in_beat_t    s1_beat;
  logic        fire;

  logic [POS_W-1:0] byte_position, byte_position_next;
  phase_t           parse_phase, parse_phase_next;
  logic [7:0]       current_tag, current_tag_next;
  logic [7:0]       record_length, record_length_next;
  logic [7:0]       bytes_left, bytes_left_next;
  target_t          record_target, record_target_next;
  logic [NL_W-1:0]  final_name_len, final_name_len_next;
  logic [PL_W-1:0]  final_pass_len, final_pass_len_next;
  logic [7:0]       final_security, final_security_next;
  logic             name_first_nonzero, name_first_nonzero_next;

  logic [LEN_W-1:0] len_ext, len_c, pos_ext;
  logic             in_range;
  logic [7:0]       b;
  logic [7:0]       off;
  logic             byte_res;
  out_beat_t        byte_beat, summary_beat;

  assign fire     = s1_valid && space_ok;
  assign in_ready = !s1_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      name_tag     <= NAME_TAG_RST;
      pass_tag     <= PASS_TAG_RST;
      pass_alt_tag <= PASS_ALT_TAG_RST;
      sec_tag      <= SEC_TAG_RST;
      sec_alt_tag  <= SEC_ALT_TAG_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_NAME_TAG:     name_tag     <= cfg_wdata;
        CFG_PASS_TAG:     pass_tag     <= cfg_wdata;
        CFG_PASS_ALT_TAG: pass_alt_tag <= cfg_wdata;
        CFG_SEC_TAG:      sec_tag      <= cfg_wdata;
        CFG_SEC_ALT_TAG:  sec_alt_tag  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_beat <= in_data;
    end
  end

  always_comb begin
    b        = s1_beat.data_byte;
    len_ext  = LEN_W'(s1_beat.pkt_len);
    len_c    = (len_ext > LEN_MAX) ? LEN_MAX : len_ext;
    pos_ext  = LEN_W'(byte_position);
    in_range = (len_c != '0) && (pos_ext < len_c);
    off      = 8'(record_length - bytes_left);
    byte_res = 1'b0;

    byte_position_next      = byte_position;
    parse_phase_next        = parse_phase;
    current_tag_next        = current_tag;
    record_length_next      = record_length;
    bytes_left_next         = bytes_left;
    record_target_next      = record_target;
    final_name_len_next     = final_name_len;
    final_pass_len_next     = final_pass_len;
    final_security_next     = final_security;
    name_first_nonzero_next = name_first_nonzero;

    if (in_range) begin
      unique case (parse_phase)
        PH_TAG: begin
          if (SUM_W'(pos_ext) + SUM_W'(2) > SUM_W'(len_c)) begin
            parse_phase_next = PH_STOP;
          end else begin
            current_tag_next = b;
            parse_phase_next = PH_LEN;
          end
        end
        PH_LEN: begin
          if (SUM_W'(pos_ext) + SUM_W'(1) + SUM_W'(b) > SUM_W'(len_c)) begin
            parse_phase_next = PH_STOP;
          end else begin
            record_target_next = TGT_NONE;
            if (current_tag == name_tag) begin
              if (32'(b) <= NAME_MAX) begin
                record_target_next      = TGT_NAME;
                final_name_len_next     = NL_W'(b);
                name_first_nonzero_next = 1'b0;
              end
            end else if (current_tag == pass_tag || current_tag == pass_alt_tag) begin
              if (32'(b) <= PASS_MAX) begin
                record_target_next  = TGT_PASS;
                final_pass_len_next = PL_W'(b);
              end
            end else if (current_tag == sec_tag || current_tag == sec_alt_tag) begin
              if (b != 8'd0) begin
                record_target_next = TGT_SEC;
              end
            end
            record_length_next = b;
            bytes_left_next    = b;
            parse_phase_next   = (b != 8'd0) ? PH_VAL : PH_TAG;
          end
        end
        PH_VAL: begin
          unique case (record_target)
            TGT_NAME: begin
              byte_res = 1'b1;
              if (off == 8'd0) begin
                name_first_nonzero_next = (b != 8'd0);
              end
            end
            TGT_PASS: byte_res = 1'b1;
            TGT_SEC: begin
              if (off == 8'd0) begin
                final_security_next = b;
              end
            end
            TGT_NONE: ;
          endcase
          bytes_left_next = 8'(bytes_left - 1'b1);
          if (bytes_left_next == 8'd0) begin
            parse_phase_next = PH_TAG;
          end
        end
        PH_STOP: ;
      endcase
      if (byte_position < POS_MAX) begin
        byte_position_next = POS_W'(byte_position + 1'b1);
      end
    end

    byte_beat               = '0;
    byte_beat.kind          = (record_target == TGT_NAME) ? KIND_NAME : KIND_PASS;
    byte_beat.offset        = 6'(off);
    byte_beat.value_byte    = b;

    summary_beat               = '0;
    summary_beat.kind          = KIND_SUMMARY;
    summary_beat.name_len      = 6'(final_name_len_next);
    summary_beat.pass_len      = 6'(final_pass_len_next);
    summary_beat.security_code = final_security_next;
    summary_beat.config_valid  = (final_name_len_next != '0) && name_first_nonzero_next;
    summary_beat.summary_last  = 1'b1;

    push        = '0;
    push.second = summary_beat;
    push.first  = byte_res ? byte_beat : summary_beat;
    if (fire) begin
      push.beats = 2'(byte_res) + 2'(s1_beat.packet_end);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid           <= 1'b0;
      byte_position      <= '0;
      parse_phase        <= PH_TAG;
      current_tag        <= '0;
      record_length      <= '0;
      bytes_left         <= '0;
      record_target      <= TGT_NONE;
      final_name_len     <= '0;
      final_pass_len     <= '0;
      final_security     <= '0;
      name_first_nonzero <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid <= 1'b1;
      end else if (fire) begin
        s1_valid <= 1'b0;
      end
      if (fire) begin
        if (s1_beat.packet_end) begin
          byte_position      <= '0;
          parse_phase        <= PH_TAG;
          current_tag        <= '0;
          record_length      <= '0;
          bytes_left         <= '0;
          record_target      <= TGT_NONE;
          final_name_len     <= '0;
          final_pass_len     <= '0;
          final_security     <= '0;
          name_first_nonzero <= 1'b0;
        end else begin
          byte_position      <= byte_position_next;
          parse_phase        <= parse_phase_next;
          current_tag        <= current_tag_next;
          record_length      <= record_length_next;
          bytes_left         <= bytes_left_next;
          record_target      <= record_target_next;
          final_name_len     <= final_name_len_next;
          final_pass_len     <= final_pass_len_next;
          final_security     <= final_security_next;
          name_first_nonzero <= name_first_nonzero_next;
        end
      end
    end
  end

`ifndef ASSERT_OFF
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (fire && s1_beat.packet_end) |=> (byte_position == '0 && parse_phase == PH_TAG))
    else $error("packet end did not clear the parse state");

  a_two_needs_summary: assert property (@(posedge clk) disable iff (rst)
    (push.beats == 2'd2) |-> (push.second.summary_last && !push.first.summary_last))
    else $error("two results pushed without a trailing summary");

  a_push_only_on_fire: assert property (@(posedge clk) disable iff (rst)
    (push.beats != 2'd0) |-> (fire && (byte_res || s1_beat.packet_end)))
    else $error("results pushed without a processed beat");
`endif

endmodule

// ===== hdl/tlv_connect_request_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLV connect request parser
// Walks a connect request payload as tag, length, value records, forwards
// name and passphrase bytes and closes each packet with a summary beat.
// ----------------------------------------------------------------------------
// The block takes one payload byte per cycle. An accepted beat is held in an
// input register and walked through the record state once the result queue
// has space, and its results land in a four-entry result queue. A byte
// yields at most one result and a packet-end beat adds a summary, so input
// keeps its one-beat-per-cycle pace as long as the output side takes one beat
// per cycle; the input register stalls only when the result queue holds more
// than two beats. Tag codes are to be written through the cfg port only while
// no packet is in flight; the block itself does not enforce this.
module tlv_connect_request_parser #(
  parameter int PAYLOAD_LEN_MAX = 2047,
  parameter int NAME_MAX        = 32,
  parameter int PASS_MAX        = 63
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  tlvcrp_pkg::in_beat_t              in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output tlvcrp_pkg::out_beat_t             out_data,
  input  logic                              cfg_wr_en,
  input  logic [tlvcrp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlvcrp_pkg::TAG_W-1:0]      cfg_wdata
);
  import tlvcrp_pkg::*;

  push_t push;
  logic  space_ok;

  tlvcrp_core #(
    .PAYLOAD_LEN_MAX (PAYLOAD_LEN_MAX),
    .NAME_MAX        (NAME_MAX),
    .PASS_MAX        (PASS_MAX)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .space_ok  (space_ok),
    .push      (push)
  );

  tlvcrp_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== tb/tlv_connect_request_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLV connect request parser testbench
// Sends connect request payloads one byte per beat and checks every name byte,
// passphrase byte and packet summary against a parser model kept in the bench.
// The run uses several tag code settings, three handshake pace patterns, a
// long output stall and a sender pause that waits for all results to drain.
// ----------------------------------------------------------------------------
module tlv_connect_request_parser_tb;
  import tlvcrp_pkg::*;

  localparam int POS_LIMIT  = 2047;
  localparam int NAME_LIMIT = 32;
  localparam int PASS_LIMIT = 63;
  localparam int TIMEOUT_NS = 4_000_000;

  typedef enum logic [1:0] {EXPECT_TAG, EXPECT_LEN, IN_VALUE, STOPPED} parse_phase_t;
  typedef enum logic [1:0] {TGT_NONE, TGT_NAME, TGT_PASS, TGT_SEC} record_target_t;

  typedef struct {
    in_beat_t beat;
    bit       drain_first;
  } pending_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_beat_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_beat_t out_data;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TAG_W-1:0] cfg_wdata = '0;

  pending_beat_t stim_beats[$];
  out_beat_t results_due[$];
  logic [7:0] pkt_body[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit long_hold_go = 1'b0;
  bit long_hold_done = 1'b0;
  int hold_left = 0;

  int stim_count = 0;
  int beats_in = 0;
  int name_bytes = 0;
  int pass_bytes = 0;
  int summaries = 0;
  int mismatches = 0;
  int settings_used = 1;

  // Tag codes as the parser should currently hold them.
  logic [7:0] name_code, pass_code, pass_alt_code, sec_code, sec_alt_code;

  // Parser state mirrored in the bench.
  int             pos;
  parse_phase_t   phase;
  logic [7:0]     cur_tag;
  logic [7:0]     rec_len;
  logic [7:0]     bytes_rem;
  record_target_t target;
  int             name_len_q;
  int             pass_len_q;
  logic [7:0]     security_q;
  bit             name_lead_nz;

  tlv_connect_request_parser i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial forever #4 clk = ~clk;

  initial begin
    #(TIMEOUT_NS);
    $display("FAILED: results differ");
    $finish;
  end

  function automatic void clear_packet_state();
    pos = 0;
    phase = EXPECT_TAG;
    cur_tag = '0;
    rec_len = '0;
    bytes_rem = '0;
    target = TGT_NONE;
    name_len_q = 0;
    pass_len_q = 0;
    security_q = '0;
    name_lead_nz = 1'b0;
  endfunction

  // Walks one input beat through the record state and queues the results
  // that it causes: at most a forwarded byte followed by the summary.
  function automatic void parse_beat(in_beat_t b);
    int plen;
    logic [7:0] off;
    out_beat_t r;
    plen = int'(b.pkt_len);
    if (plen != 0 && pos < plen) begin
      case (phase)
        EXPECT_TAG: begin
          if (pos + 2 > plen) begin
            phase = STOPPED;
          end else begin
            cur_tag = b.data_byte;
            phase = EXPECT_LEN;
          end
        end
        EXPECT_LEN: begin
          if (pos + 1 + int'(b.data_byte) > plen) begin
            phase = STOPPED;
          end else begin
            target = TGT_NONE;
            if (cur_tag == name_code) begin
              if (b.data_byte <= NAME_LIMIT) begin
                target = TGT_NAME;
                name_len_q = b.data_byte;
                name_lead_nz = 1'b0;
              end
            end else if (cur_tag == pass_code || cur_tag == pass_alt_code) begin
              if (b.data_byte <= PASS_LIMIT) begin
                target = TGT_PASS;
                pass_len_q = b.data_byte;
              end
            end else if (cur_tag == sec_code || cur_tag == sec_alt_code) begin
              if (b.data_byte != 0) target = TGT_SEC;
            end
            rec_len = b.data_byte;
            bytes_rem = b.data_byte;
            phase = (b.data_byte != 0) ? IN_VALUE : EXPECT_TAG;
          end
        end
        IN_VALUE: begin
          off = rec_len - bytes_rem;
          if (target == TGT_NAME || target == TGT_PASS) begin
            if (target == TGT_NAME && off == 0) name_lead_nz = (b.data_byte != 0);
            r = '0;
            r.kind = (target == TGT_NAME) ? KIND_NAME : KIND_PASS;
            r.offset = off[5:0];
            r.value_byte = b.data_byte;
            results_due.push_back(r);
          end else if (target == TGT_SEC && off == 0) begin
            security_q = b.data_byte;
          end
          bytes_rem = bytes_rem - 8'd1;
          if (bytes_rem == 0) phase = EXPECT_TAG;
        end
        default: ;
      endcase
      if (pos < POS_LIMIT) pos++;
    end
    if (b.packet_end) begin
      r = '0;
      r.kind = KIND_SUMMARY;
      r.name_len = 6'(name_len_q);
      r.pass_len = 6'(pass_len_q);
      r.security_code = security_q;
      r.config_valid = (name_len_q != 0) && name_lead_nz;
      r.summary_last = 1'b1;
      results_due.push_back(r);
      clear_packet_state();
    end
  endfunction

  function automatic string beat_str(out_beat_t x);
    return $sformatf({"kind=%0d off=%0d byte=%02h name_len=%0d pass_len=%0d",
                      " sec=%02h vld=%0d last=%0d"},
                     x.kind, x.offset, x.value_byte, x.name_len, x.pass_len,
                     x.security_code, x.config_valid, x.summary_last);
  endfunction

  // Sender.
  always @(posedge clk) begin : sender
    pending_beat_t next_item;
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else if (!in_valid || in_ready) begin
      if (stim_beats.size() != 0 && $urandom_range(99) >= send_idle_pct &&
          !(stim_beats[0].drain_first && results_due.size() != 0)) begin
        next_item = stim_beats.pop_front();
        in_valid <= 1'b1;
        in_data <= next_item.beat;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver, with one long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (long_hold_go && !long_hold_done) begin
      out_ready <= 1'b0;
      hold_left <= 250;
      long_hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predicts on every accepted input beat and checks every result beat.
  always @(posedge clk) begin : monitor
    out_beat_t want;
    if (rst) begin
      name_code = NAME_TAG_RST;
      pass_code = PASS_TAG_RST;
      pass_alt_code = PASS_ALT_TAG_RST;
      sec_code = SEC_TAG_RST;
      sec_alt_code = SEC_ALT_TAG_RST;
      clear_packet_state();
    end else begin
      if (in_valid && in_ready) begin
        beats_in++;
        parse_beat(in_data);
      end
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result beat: %s", beat_str(out_data));
        end else begin
          want = results_due.pop_front();
          case (want.kind)
            KIND_NAME: name_bytes++;
            KIND_PASS: pass_bytes++;
            default: summaries++;
          endcase
          if (out_data.kind !== want.kind || out_data.offset !== want.offset ||
              out_data.value_byte !== want.value_byte ||
              out_data.name_len !== want.name_len ||
              out_data.pass_len !== want.pass_len ||
              out_data.security_code !== want.security_code ||
              out_data.config_valid !== want.config_valid ||
              out_data.summary_last !== want.summary_last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch at %0t: expected %s, got %s", $realtime,
                       beat_str(want), beat_str(out_data));
          end
        end
      end
    end
  end

  function automatic void push_beat(logic [7:0] b, int plen, bit last, bit drain);
    pending_beat_t p;
    p.beat.data_byte = b;
    p.beat.pkt_len = 11'(plen);
    p.beat.packet_end = last;
    p.drain_first = drain;
    stim_beats.push_back(p);
    if (plen != 0 || last) stim_count++;
  endfunction

  function automatic void push_packet(int plen, int n_send, bit with_end, bit drain);
    for (int i = 0; i < n_send; i++)
      push_beat(pkt_body[i], plen, with_end && i == n_send - 1, drain && i == 0);
  endfunction

  // Fills pkt_body with one to four records of random kind and content.
  function automatic void build_body();
    int n_rec;
    int sel;
    int len;
    bit over;
    logic [7:0] tag;
    pkt_body.delete();
    n_rec = $urandom_range(1, 4);
    for (int r = 0; r < n_rec; r++) begin
      sel = $urandom_range(0, 9);
      over = ($urandom_range(0, 9) == 0);
      case (sel)
        0, 1: begin
          tag = name_code;
          len = over ? $urandom_range(NAME_LIMIT + 1, 40) : $urandom_range(0, NAME_LIMIT);
        end
        2, 3: begin
          tag = (sel == 2) ? pass_code : pass_alt_code;
          len = over ? $urandom_range(PASS_LIMIT + 1, 70) : $urandom_range(0, PASS_LIMIT);
        end
        4, 5: begin
          tag = (sel == 4) ? sec_code : sec_alt_code;
          len = $urandom_range(0, 3);
        end
        default: begin
          tag = 8'($urandom_range(0, 255));
          len = over ? 255 : $urandom_range(0, 6);
        end
      endcase
      pkt_body.push_back(tag);
      pkt_body.push_back(8'(len));
      for (int i = 0; i < len; i++) begin
        if (i == 0 && tag == name_code && $urandom_range(0, 4) == 0) pkt_body.push_back(8'h00);
        else pkt_body.push_back(8'($urandom_range(0, 255)));
      end
    end
  endfunction

  // Mostly well-formed packets; the rest end early, carry a short or an oversized
  // length, trail a lone byte, are empty, follow empty beats, or never end.
  function automatic void queue_random_packet(bit drain);
    int mode;
    int n;
    build_body();
    n = pkt_body.size();
    mode = $urandom_range(0, 19);
    if (mode < 11) begin
      push_packet(n, n, 1'b1, drain);
    end else if (mode < 13) begin
      push_packet(n, $urandom_range(1, n - 1), 1'b1, drain);
    end else if (mode < 15) begin
      push_packet($urandom_range(1, n - 1), n, 1'b1, drain);
    end else if (mode == 15) begin
      pkt_body.push_back(8'($urandom_range(0, 255)));
      push_packet(n + 1, n + 1, 1'b1, drain);
    end else if (mode == 16) begin
      push_packet($urandom_range(n + 1, POS_LIMIT), n, 1'b1, drain);
    end else if (mode == 17) begin
      push_beat(8'($urandom_range(0, 255)), 0, 1'b1, drain);
    end else if (mode == 18) begin
      repeat ($urandom_range(1, 3)) push_beat(8'($urandom_range(0, 255)), 0, 1'b0, drain);
      push_packet(n, n, 1'b1, 1'b0);
    end else begin
      push_packet(n, $urandom_range(1, n), 1'b0, drain);
    end
  endfunction

  task automatic write_tag(logic [CFG_IDX_W-1:0] idx, logic [TAG_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_NAME_TAG:     name_code = val;
      CFG_PASS_TAG:     pass_code = val;
      CFG_PASS_ALT_TAG: pass_alt_code = val;
      CFG_SEC_TAG:      sec_code = val;
      CFG_SEC_ALT_TAG:  sec_alt_code = val;
      default: ;
    endcase
  endtask

  task automatic set_tags(logic [7:0] n, logic [7:0] p, logic [7:0] pa,
                          logic [7:0] s, logic [7:0] sa);
    write_tag(CFG_NAME_TAG, n);
    write_tag(CFG_PASS_TAG, p);
    write_tag(CFG_PASS_ALT_TAG, pa);
    write_tag(CFG_SEC_TAG, s);
    write_tag(CFG_SEC_ALT_TAG, sa);
    settings_used++;
  endtask

  task automatic wait_idle();
    while (stim_beats.size() != 0 || in_valid || results_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin : stimulus
    int goal;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 33;
    recv_idle_pct = 76;

    // Empty payload, an ignored empty beat, then short packets that cover
    // every record kind, a skipped zero-length security record, a record
    // running past the end, a lone trailing tag and an early end.
    push_beat(8'hFF, 0, 1'b1, 1'b0);
    push_beat(8'h00, 0, 1'b0, 1'b0);
    pkt_body = '{NAME_TAG_RST, 8'd2, 8'h41, 8'h42, PASS_TAG_RST, 8'd1, 8'hFF,
                 SEC_TAG_RST, 8'd1, 8'h07, 8'h99};
    push_packet(11, 11, 1'b1, 1'b0);
    pkt_body = '{NAME_TAG_RST, 8'd1, 8'h00, PASS_ALT_TAG_RST, 8'd0,
                 SEC_ALT_TAG_RST, 8'd0, PASS_TAG_RST, 8'd5};
    push_packet(9, 9, 1'b1, 1'b0);
    pkt_body = '{NAME_TAG_RST, 8'd3, 8'h55};
    push_packet(10, 3, 1'b1, 1'b0);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 2) begin
        send_idle_pct = 33;
        recv_idle_pct = 76;
      end else if (ph < 4) begin
        send_idle_pct = 76;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (ph)
        1: set_tags(8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00);
        2: set_tags(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        3, 4: set_tags(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
        5: set_tags(NAME_TAG_RST, PASS_TAG_RST, PASS_ALT_TAG_RST, SEC_TAG_RST,
                    SEC_ALT_TAG_RST);
        default: ;
      endcase
      goal = stim_count + 230;
      queue_random_packet(ph == 3);
      while (stim_count < goal) queue_random_packet($urandom_range(0, 39) == 0);
      push_beat(8'($urandom_range(0, 255)), 0, 1'b1, 1'b0);
      if (ph == 4) long_hold_go = 1'b1;
      wait_idle();
    end

    repeat (10) @(posedge clk);
    $display("Sent %0d payload beats under %0d tag settings and three pace patterns.",
             beats_in, settings_used);
    $display("Checked %0d name bytes, %0d passphrase bytes and %0d packet summaries.",
             name_bytes, pass_bytes, summaries);
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/tlvcrp_pkg.sv
hdl/tlvcrp_out_queue.sv
hdl/tlvcrp_core.sv
hdl/tlv_connect_request_parser.sv
tb/tlv_connect_request_parser_tb.sv
